>>> sv/dvrt_pkg.sv
// Package for the distance-vector route table: codes, entry record and helpers.
package dvrt_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned ENTRIES_DEF  = 32;
  localparam int unsigned INF_DIST_DEF = 65535;

  // Request operation codes
  localparam logic [2:0] OP_ADD_CONN = 3'd0;
  localparam logic [2:0] OP_ADVERT   = 3'd1;
  localparam logic [2:0] OP_LINK_DN  = 3'd2;
  localparam logic [2:0] OP_LINK_UP  = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_UPDATED   = 3'd0;
  localparam logic [2:0] ST_UNCHANGED = 3'd1;
  localparam logic [2:0] ST_INSERTED  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BADIDX    = 3'd4;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_CALC,
    S_DONE
  } state_t;

  // One table row
  typedef struct packed {
    logic [31:0] network;
    logic [5:0]  prefix;
    logic [15:0] distance;
    logic [31:0] next_hop;
    logic        direct;
    logic        connected;
    logic [31:0] iface;
    logic [15:0] base;
  } entry_t;

  // Leading-ones mask of a prefix length (0..32)
  function automatic logic [31:0] prefix_mask(input logic [5:0] p);
    logic [31:0] m;
    if (p == 6'd0) begin
      m = 32'd0;
    end else begin
      m = 32'hFFFF_FFFF << (6'd32 - p);
    end
    return m;
  endfunction

endpackage

>>> sv/distance_vector_route_table_unit.sv
// Top level of the distance-vector route table: sequencer, table memory, result register.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one request: op, address, prefix
//    length, distance, sender address and entry index. Output channel
//    (out_valid/out_ready) returns exactly one result per request.
//  - Add-connected and advertisement requests scan every stored entry once
//    through the single table read port, one entry per cycle.
//  - Link down on a connected entry also scans the table; link up, read and
//    link down on a plain entry take a single row check; bad index and
//    unknown ops go straight to the result.
//  - One request is in flight at a time; in_ready is high only while idle, so
//    a new request is taken in the cycle after the result is loaded.
//  - The result sits in an output register; the table is not touched again
//    until the next request, and a stalled receiver only holds the block in
//    its final state until the register frees up.
//  - Reset (synchronous, active low) empties the table by clearing the fill
//    count; no clearing pass over the memory is needed.
module distance_vector_route_table_unit #(
  parameter int unsigned ENTRIES       = dvrt_pkg::ENTRIES_DEF,
  parameter int unsigned INFINITY_DIST = dvrt_pkg::INF_DIST_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_address,
  input  logic [5:0]  in_prefix_len,
  input  logic [15:0] in_distance_in,
  input  logic [31:0] in_sender_address,
  input  logic [4:0]  in_entry_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [4:0]  out_result_index,
  output logic [31:0] out_network_out,
  output logic [5:0]  out_prefix_out,
  output logic [15:0] out_distance_out,
  output logic [31:0] out_next_hop,
  output logic        out_direct_out
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [15:0] INF_D = 16'(INFINITY_DIST);
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  dvrt_pkg::state_t state_r, state_nxt;

  // Request registers
  logic [2:0]  op_r;
  logic [31:0] addr_r, net_r, sender_r;
  logic [5:0]  p_r;
  logic [15:0] dist_r;
  logic [4:0]  idx_r;
  logic        bad_r;

  // Scan and result working registers
  logic [CW-1:0]       rd_i_r;
  logic                pend_r;
  logic [IW-1:0]       pidx_r;
  logic                cost_found_r;
  logic [15:0]         cost_r;
  logic                hit_r;
  logic [IW-1:0]       hit_idx_r;
  dvrt_pkg::entry_t    hit_rec_r;
  dvrt_pkg::entry_t    rec_r;
  logic [15:0]         nd_r;
  logic [CW-1:0]       cnt_r;

  // Table memory
  dvrt_pkg::entry_t mem [ENTRIES];
  dvrt_pkg::entry_t rdata_r;
  logic [IW-1:0]    raddr;
  logic             mem_we;
  logic [IW-1:0]    waddr;
  dvrt_pkg::entry_t wdata;

  // Output register
  logic        out_valid_r;
  logic [2:0]  status_r;
  logic [4:0]  res_idx_r;
  dvrt_pkg::entry_t res_rec_r;

  // Combinational helpers
  logic             accept;
  logic [5:0]       in_p;
  logic [15:0]      in_d;
  logic             idx_bad;
  logic             scan_issue;
  logic             scan_end;
  logic             fire;
  logic [16:0]      nd_sum;
  logic [2:0]       res_status;
  logic [4:0]       res_idx;
  logic             res_show;
  dvrt_pkg::entry_t res_rec;
  logic             res_write;
  logic [IW-1:0]    res_addr;
  logic             res_inc;
  logic             kill_hit;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == dvrt_pkg::S_IDLE);
  assign in_p     = (in_prefix_len > 6'd32) ? 6'd32 : in_prefix_len;
  assign in_d     = (in_distance_in > INF_D) ? INF_D : in_distance_in;
  assign idx_bad  = (32'(in_entry_index) >= 32'(cnt_r));

  assign scan_issue = (state_r == dvrt_pkg::S_SCAN) && (rd_i_r < cnt_r);
  assign scan_end   = (state_r == dvrt_pkg::S_SCAN) && !scan_issue && !pend_r;
  assign fire       = (state_r == dvrt_pkg::S_DONE) && (!out_valid_r || out_ready);
  assign nd_sum     = {1'b0, dist_r} + {1'b0, cost_r};

  // Link-down match on a scanned row
  assign kill_hit = pend_r && (op_r == dvrt_pkg::OP_LINK_DN) && !rdata_r.direct &&
                    ((rdata_r.next_hop & dvrt_pkg::prefix_mask(rec_r.prefix)) == rec_r.network);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dvrt_pkg::S_IDLE: begin
        if (accept) begin
          if (in_op == dvrt_pkg::OP_ADD_CONN || in_op == dvrt_pkg::OP_ADVERT) begin
            state_nxt = dvrt_pkg::S_SCAN;
          end else if ((in_op == dvrt_pkg::OP_LINK_DN || in_op == dvrt_pkg::OP_LINK_UP ||
                        in_op == dvrt_pkg::OP_READ) && !idx_bad) begin
            state_nxt = dvrt_pkg::S_CHECK;
          end else begin
            state_nxt = dvrt_pkg::S_DONE;
          end
        end
      end
      dvrt_pkg::S_CHECK: begin
        if (op_r == dvrt_pkg::OP_LINK_DN && rdata_r.connected) begin
          state_nxt = dvrt_pkg::S_SCAN;
        end else begin
          state_nxt = dvrt_pkg::S_DONE;
        end
      end
      dvrt_pkg::S_SCAN: begin
        if (scan_end) begin
          state_nxt = (op_r == dvrt_pkg::OP_LINK_DN) ? dvrt_pkg::S_DONE : dvrt_pkg::S_CALC;
        end
      end
      dvrt_pkg::S_CALC: state_nxt = dvrt_pkg::S_DONE;
      dvrt_pkg::S_DONE: begin
        if (fire) begin
          state_nxt = dvrt_pkg::S_IDLE;
        end
      end
      default: state_nxt = dvrt_pkg::S_IDLE;
    endcase
  end

  // Result and write-back for the finishing request
  always_comb begin
    res_status = dvrt_pkg::ST_UNCHANGED;
    res_idx    = 5'd0;
    res_show   = 1'b0;
    res_rec    = rec_r;
    res_write  = 1'b0;
    res_addr   = hit_idx_r;
    res_inc    = 1'b0;
    if (bad_r) begin
      res_status = dvrt_pkg::ST_BADIDX;
      res_idx    = idx_r;
    end else if (op_r == dvrt_pkg::OP_ADD_CONN || op_r == dvrt_pkg::OP_ADVERT) begin
      if (hit_r) begin
        res_idx  = 5'(hit_idx_r);
        res_show = 1'b1;
        res_rec  = hit_rec_r;
        if (op_r == dvrt_pkg::OP_ADD_CONN) begin
          res_status        = dvrt_pkg::ST_UPDATED;
          res_rec.connected = 1'b1;
          res_rec.iface     = addr_r;
          res_rec.base      = dist_r;
          res_rec.distance  = nd_r;
          res_rec.direct    = 1'b1;
          res_rec.next_hop  = 32'd0;
          res_write         = 1'b1;
        end else if (nd_r < hit_rec_r.distance) begin
          res_status       = dvrt_pkg::ST_UPDATED;
          res_rec.distance = nd_r;
          res_rec.direct   = (cost_r == 16'd0);
          res_rec.next_hop = (cost_r == 16'd0) ? 32'd0 : sender_r;
          res_write        = 1'b1;
        end
      end else if (cnt_r >= FULL_CNT) begin
        res_status = dvrt_pkg::ST_FULL;
      end else begin
        res_status        = dvrt_pkg::ST_INSERTED;
        res_idx           = 5'(cnt_r);
        res_show          = 1'b1;
        res_addr          = IW'(cnt_r);
        res_rec.network   = net_r;
        res_rec.prefix    = p_r;
        res_rec.distance  = nd_r;
        res_rec.connected = (op_r == dvrt_pkg::OP_ADD_CONN);
        res_rec.iface     = (op_r == dvrt_pkg::OP_ADD_CONN) ? addr_r : 32'd0;
        res_rec.base      = (op_r == dvrt_pkg::OP_ADD_CONN) ? dist_r : 16'd0;
        res_rec.direct    = (op_r == dvrt_pkg::OP_ADD_CONN) || (cost_r == 16'd0);
        res_rec.next_hop  = res_rec.direct ? 32'd0 : sender_r;
        res_write         = 1'b1;
        res_inc           = 1'b1;
      end
    end else if (op_r == dvrt_pkg::OP_LINK_DN) begin
      res_status       = dvrt_pkg::ST_UPDATED;
      res_idx          = idx_r;
      res_show         = 1'b1;
      res_addr         = IW'(idx_r);
      res_rec.distance = INF_D;
      res_write        = 1'b1;
    end else if (op_r == dvrt_pkg::OP_LINK_UP) begin
      res_status       = dvrt_pkg::ST_UPDATED;
      res_idx          = idx_r;
      res_show         = 1'b1;
      res_addr         = IW'(idx_r);
      res_rec.distance = rec_r.base;
      res_rec.direct   = 1'b1;
      res_rec.next_hop = 32'd0;
      res_write        = 1'b1;
    end else if (op_r == dvrt_pkg::OP_READ) begin
      res_idx  = idx_r;
      res_show = 1'b1;
    end
  end

  // Memory port control
  always_comb begin
    raddr  = rd_i_r[IW-1:0];
    if (state_r == dvrt_pkg::S_IDLE) begin
      raddr = IW'(in_entry_index);
    end
    mem_we = 1'b0;
    waddr  = pidx_r;
    wdata  = rdata_r;
    if (state_r == dvrt_pkg::S_SCAN) begin
      mem_we         = kill_hit;
      wdata.distance = INF_D;
    end else if (fire) begin
      mem_we = res_write;
      waddr  = res_addr;
      wdata  = res_rec;
    end
  end

  // Table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dvrt_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      rd_i_r      <= '0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= scan_issue;
      rd_i_r  <= scan_issue ? rd_i_r + CW'(1) :
                 ((state_r == dvrt_pkg::S_SCAN) ? rd_i_r : '0);
      if (fire && res_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture and scan datapath
  always_ff @(posedge clk) begin
    pidx_r <= rd_i_r[IW-1:0];
    if (accept) begin
      op_r         <= in_op;
      addr_r       <= in_address;
      net_r        <= in_address & dvrt_pkg::prefix_mask(in_p);
      p_r          <= in_p;
      dist_r       <= in_d;
      sender_r     <= in_sender_address;
      idx_r        <= in_entry_index;
      bad_r        <= (in_op == dvrt_pkg::OP_LINK_DN || in_op == dvrt_pkg::OP_LINK_UP ||
                       in_op == dvrt_pkg::OP_READ) && idx_bad;
      cost_found_r <= 1'b0;
      cost_r       <= 16'd0;
      hit_r        <= 1'b0;
    end
    // Row check for the chosen entry
    if (state_r == dvrt_pkg::S_CHECK) begin
      rec_r <= rdata_r;
      if (op_r != dvrt_pkg::OP_READ && !rdata_r.connected) begin
        bad_r <= 1'b1;
      end
    end
    // Link cost and exact-match search, first hit wins
    if (pend_r && op_r != dvrt_pkg::OP_LINK_DN) begin
      if (op_r == dvrt_pkg::OP_ADVERT && !cost_found_r && rdata_r.connected) begin
        if (sender_r == rdata_r.iface) begin
          cost_found_r <= 1'b1;
          cost_r       <= 16'd0;
        end else if ((sender_r & dvrt_pkg::prefix_mask(rdata_r.prefix)) ==
                     rdata_r.network) begin
          cost_found_r <= 1'b1;
          cost_r       <= rdata_r.distance;
        end
      end
      if (!hit_r && rdata_r.network == net_r && rdata_r.prefix == p_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= pidx_r;
        hit_rec_r <= rdata_r;
      end
    end
    // Saturating new distance
    if (state_r == dvrt_pkg::S_CALC) begin
      nd_r <= (nd_sum > {1'b0, INF_D}) ? INF_D : nd_sum[15:0];
    end
    // Result payload
    if (fire) begin
      status_r  <= res_status;
      res_idx_r <= res_idx;
      res_rec_r <= res_show ? res_rec : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_result_index = res_idx_r;
  assign out_network_out  = res_rec_r.network;
  assign out_prefix_out   = res_rec_r.prefix;
  assign out_distance_out = res_rec_r.distance;
  assign out_next_hop     = res_rec_r.next_hop;
  assign out_direct_out   = res_rec_r.direct;

`ifndef SYNTHESIS
  // Fill count never passes the table size
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= FULL_CNT)
    else $error("entry count above table size");

  // Fill count only steps up by one
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && cnt_r != $past(cnt_r)) |-> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("entry count jumped");

  // No table write while idle
  a_idle_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dvrt_pkg::S_IDLE) |-> !mem_we)
    else $error("table write while idle");

  // A result appears only after the finishing state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> $past(state_r == dvrt_pkg::S_DONE))
    else $error("result without finishing state");
`endif

endmodule
